>>> rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell, sorted_priority_queue_top and spq_checker.
package spq_pkg;

  localparam int unsigned PrioW  = 3;
  localparam int unsigned IdentW = 30;
  localparam int unsigned OccW   = 5;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [IdentW-1:0] ident;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds an item, shifts right on insert, left on remove.
// Depends on spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                left_occ_i,
  input  logic                left_sh_i,
  input  spq_pkg::entry_t     left_data_i,
  input  spq_pkg::entry_t     right_data_i,
  output logic                sh_o,
  output spq_pkg::entry_t     data_o
);

  spq_pkg::entry_t data_q;
  spq_pkg::entry_t data_d;

  assign sh_o   = occ_i && (data_q.prio > ctrl_i.new_entry.prio);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.enq) begin
      if (left_sh_i) begin
        data_d = left_data_i;
      end else if (left_occ_i && (sh_o || !occ_i)) begin
        data_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.deq) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> rtl/sorted_priority_queue_top.sv
// Sorted priority queue: a row of CAPACITY cells plus an entry count and result register.
// Depends on spq_pkg and spq_cell.
//
// For each item (enqueue or dequeue), every cell compares its priority with
// the new item and shifts in the same cycle, so busy never rises and a new item can be
// started in every cycle. The result appears on the result ports, marked by done_o, in
// the cycle after the item is started. Equal priorities leave in arrival order. An
// enqueue into a full queue is dropped with status 1; a dequeue from an empty queue
// returns status 2. occupancy_o is the count after the item, taken modulo 32.
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [spq_pkg::PrioW-1:0]    priority_req_i,
  input  logic [spq_pkg::IdentW-1:0]   ident_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic                         out_valid_o,
  output logic [spq_pkg::PrioW-1:0]    out_priority_o,
  output logic [spq_pkg::IdentW-1:0]   out_ident_o,
  output logic                         is_empty_now_o,
  output logic [spq_pkg::OccW-1:0]     occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  logic [CntW-1:0]     count_q, count_d;
  logic                accept, full, empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::status_e    status_d;

  logic                cell_sh  [CAPACITY];
  logic                cell_occ [CAPACITY];
  spq_pkg::entry_t     cell_data[CAPACITY];

  logic                        done_q;
  spq_pkg::status_e            status_q;
  logic                        out_valid_q, out_valid_d;
  spq_pkg::entry_t             out_entry_q, out_entry_d;
  logic                        empty_q;
  logic [spq_pkg::OccW-1:0]    occ_q, occ_d;
  logic [31:0]                 cnt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntMax);
  assign empty  = (count_q == '0);

  assign ctrl.enq       = accept && (kind_i == spq_pkg::KIND_ENQ) && !full;
  assign ctrl.deq       = accept && (kind_i == spq_pkg::KIND_DEQ) && !empty;
  assign ctrl.new_entry = '{prio: priority_req_i, ident: ident_i};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (cell_occ[i]),
        .left_occ_i  (1'b1),
        .left_sh_i   (1'b0),
        .left_data_i (ctrl.new_entry),
        .right_data_i(cell_data[(i + 1) % CAPACITY]),
        .sh_o        (cell_sh[i]),
        .data_o      (cell_data[i])
      );
    end else begin : g_body
      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (cell_occ[i]),
        .left_occ_i  (cell_occ[i-1]),
        .left_sh_i   (cell_sh[i-1]),
        .left_data_i (cell_data[i-1]),
        .right_data_i(cell_data[(i + 1) % CAPACITY]),
        .sh_o        (cell_sh[i]),
        .data_o      (cell_data[i])
      );
    end
  end

  always_comb begin
    count_d     = count_q;
    status_d    = spq_pkg::ST_OK;
    out_valid_d = 1'b0;
    out_entry_d = '0;
    unique case (kind_i)
      spq_pkg::KIND_ENQ: begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      spq_pkg::KIND_DEQ: begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          count_d     = count_q - CntW'(1);
          out_valid_d = 1'b1;
          out_entry_d = cell_data[0];
        end
      end
      default: status_d = spq_pkg::ST_OK;
    endcase
    cnt_ext = 32'(count_d);
    occ_d   = cnt_ext[spq_pkg::OccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      out_entry_q <= out_entry_d;
      empty_q     <= (count_d == '0);
      occ_q       <= occ_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_valid_o    = out_valid_q;
  assign out_priority_o = out_entry_q.prio;
  assign out_ident_o    = out_entry_q.ident;
  assign is_empty_now_o = empty_q;
  assign occupancy_o    = occ_q;

endmodule

>>> rtl/spq_checker.sv
// Port-level checks for sorted_priority_queue_top, attached by bind.
// Depends on spq_pkg.
module spq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic                       out_valid_o,
  input logic                       is_empty_now_o,
  input logic [spq_pkg::OccW-1:0]   occupancy_o
);

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("missing result after accepted item");

  a_done_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without accepted item");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_valid_o) |-> (status_o == spq_pkg::ST_OK))
    else $error("returned item with error status");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == spq_pkg::ST_EMPTY)) |-> (is_empty_now_o && !out_valid_o))
    else $error("empty dequeue reported inconsistently");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && (status_o == spq_pkg::ST_OK) && !out_valid_o)
      |-> (occupancy_o == $past(occupancy_o) + spq_pkg::OccW'(1)))
    else $error("enqueue did not advance occupancy");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
